// File: rtl/core/windowed_pid_angular_core_defines.svh
// Assertion macros used by the controller of the windowed PID core.
`ifndef WINDOWED_PID_ANGULAR_CORE_DEFINES_SVH
`define WINDOWED_PID_ANGULAR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define WPA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("windowed pid core: assertion failed");
// Check that a condition never holds outside reset.
`define WPA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`WPA_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define WPA_ASSERT(lbl, clk, rst_n, prop)
`define WPA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/core/wpa_pkg.sv
`default_nettype none
package wpa_pkg;

	localparam int HISTORY_DEPTH_DEF = 16;
	localparam int DATA_W            = 32;
	localparam int SUM_W             = 40;
	localparam int DIFF_W            = 33;
	localparam int DIV_W             = 49;
	localparam int WIDE_W            = 50;
	localparam int PROD_W            = 64;
	localparam int FRAC_W            = 16;
	localparam int COUNT_OUT_W       = 4;
	localparam int CFG_IDX_W         = 2;

	localparam logic signed [DATA_W-1:0] Q_PI     = 32'sd205887;
	localparam logic signed [DATA_W-1:0] Q_TWO_PI = 32'sd411775;
	localparam logic signed [DATA_W-1:0] S32_MAX  = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] S32_MIN  = 32'sh80000000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP,
		REG_GAIN_INTEG,
		REG_GAIN_DERIV,
		REG_ANGULAR_MODE
	} cfg_reg_t;

	// Datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_RD_HEAD,
		OP_DROP,
		OP_RD_PREV,
		OP_TAKE_PREV,
		OP_SELF_PREV,
		OP_PUSH,
		OP_DIV_MEAN,
		OP_DIV_DERIV,
		OP_MUL_P,
		OP_MUL_I,
		OP_MUL_D,
		OP_ACC,
		OP_OUT_RUN,
		OP_OUT_SKIP,
		OP_OUT_CLEAR
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic func;
		logic dt_zero;
		logic full;
		logic empty;
		logic div_done;
	} dp_status_t;

	// Clamp a wide signed value to signed 32 bits
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(S32_MAX);
		lo = WIDE_W'(S32_MIN);
		if (x > hi) begin
			return S32_MAX;
		end else if (x < lo) begin
			return S32_MIN;
		end
		return DATA_W'(x);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/wpa_if.sv
`default_nettype none
// Update item channel
interface wpa_req_if;
	logic                              valid;
	logic                              ready;
	logic                              func;
	logic [wpa_pkg::DATA_W-1:0]        step_time;
	logic signed [wpa_pkg::DATA_W-1:0] measured;
	logic signed [wpa_pkg::DATA_W-1:0] target;
	modport source(output valid, func, step_time, measured, target, input ready);
	modport sink(input valid, func, step_time, measured, target, output ready);
endinterface

// Result channel
interface wpa_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [wpa_pkg::DATA_W-1:0]   drive;
	logic signed [wpa_pkg::DATA_W-1:0]   error_out;
	logic [wpa_pkg::COUNT_OUT_W-1:0]     window_count;
	modport source(output valid, drive, error_out, window_count, input ready);
	modport sink(input valid, drive, error_out, window_count, output ready);
endinterface

// Configuration write channel
interface wpa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wpa_pkg::CFG_IDX_W-1:0]  index;
	logic [wpa_pkg::DATA_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/windowed_pid_angular_core.sv
// Windowed PID controller step, signed Q16.16, with optional angular error wrap.
// Channels: req carries one item (func, step_time, measured, target); rsp
// returns one result (drive, error_out, window_count) per item; cfg writes
// the gains and the angular mode flag by register index and is always ready.
// Each channel moves a transfer on a rising edge with valid and ready high.
// An update item runs two 49-step restoring divisions (window mean, then
// the derivative) on one shared bit-serial divider, plus ring memory reads
// and three products on one 32x32 multiplier. A clear item or a zero step
// time goes straight to the result. One item is in work at a time; req is
// ready in idle, so a new item waits until the one in work is finished.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls, a finished item holds until rsp frees.
// Reset clears the gains, the mode flag, the ring pointers and the running
// sum; the ring memory itself needs no clearing since the pointers bound it.
`default_nettype none
module windowed_pid_angular_core #(
	parameter int HISTORY_DEPTH = wpa_pkg::HISTORY_DEPTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	wpa_req_if.sink    req,
	wpa_rsp_if.source  rsp,
	wpa_cfg_if.sink    cfg
);

	wpa_pkg::dp_cmd_t    cmd;
	wpa_pkg::dp_status_t status;

	assign cfg.ready = 1'b1;

	wpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.status   (status),
		.cmd      (cmd)
	);

	wpa_datapath #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_idx     (cfg.index),
		.cfg_data    (cfg.data),
		.in_func     (req.func),
		.in_step_time(req.step_time),
		.in_measured (req.measured),
		.in_target   (req.target),
		.cmd         (cmd),
		.status      (status),
		.drive       (rsp.drive),
		.error_out   (rsp.error_out),
		.window_count(rsp.window_count)
	);

endmodule
`default_nettype wire

// File: rtl/core/wpa_ram.sv
`default_nettype none
module wpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/wpa_div.sv
`default_nettype none
module wpa_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic                                neg,
	input  wire logic [wpa_pkg::DIV_W-1:0]           mag,
	input  wire logic [wpa_pkg::DATA_W-1:0]          den,
	output logic signed [wpa_pkg::WIDE_W-1:0]        quo,
	output logic                                     done
);

	localparam int STEP_W = $clog2(wpa_pkg::DIV_W);

	logic                           busy_q;
	logic                           done_q;
	logic [STEP_W-1:0]              step_q;
	logic [wpa_pkg::DATA_W:0]       rem_q;
	logic [wpa_pkg::DIV_W-1:0]      quo_q;
	logic [wpa_pkg::DATA_W-1:0]     den_q;
	logic                           neg_q;

	logic [wpa_pkg::DATA_W:0]       rem_sh;
	logic                           fits;
	logic signed [wpa_pkg::WIDE_W-1:0] q_pos;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q[wpa_pkg::DATA_W-1:0], quo_q[wpa_pkg::DIV_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
		q_pos  = $signed({1'b0, quo_q});
		quo    = neg_q ? -q_pos : q_pos;
	end

	assign done = done_q;

	// Control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(wpa_pkg::DIV_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[wpa_pkg::DIV_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/wpa_datapath.sv
`default_nettype none
module wpa_datapath #(
	parameter int HISTORY_DEPTH = wpa_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [wpa_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  wire logic [wpa_pkg::DATA_W-1:0]           cfg_data,
	input  wire logic                                 in_func,
	input  wire logic [wpa_pkg::DATA_W-1:0]           in_step_time,
	input  wire logic signed [wpa_pkg::DATA_W-1:0]    in_measured,
	input  wire logic signed [wpa_pkg::DATA_W-1:0]    in_target,
	input  wire wpa_pkg::dp_cmd_t                     cmd,
	output wpa_pkg::dp_status_t                       status,
	output logic signed [wpa_pkg::DATA_W-1:0]         drive,
	output logic signed [wpa_pkg::DATA_W-1:0]         error_out,
	output logic [wpa_pkg::COUNT_OUT_W-1:0]           window_count
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [IDX_W:0]   DEPTH_W  = (IDX_W + 1)'(HISTORY_DEPTH);

	// Configuration
	logic signed [wpa_pkg::DATA_W-1:0] gain_prop_q;
	logic signed [wpa_pkg::DATA_W-1:0] gain_integ_q;
	logic signed [wpa_pkg::DATA_W-1:0] gain_deriv_q;
	logic                              angular_q;

	// Item and window state
	logic                              func_q;
	logic [wpa_pkg::DATA_W-1:0]        dt_q;
	logic signed [wpa_pkg::DATA_W-1:0] e_q;
	logic                              full_q;
	logic                              empty_q;
	logic [IDX_W-1:0]                  head_q;
	logic [IDX_W-1:0]                  tail_q;
	logic signed [wpa_pkg::SUM_W-1:0]  sum_q;

	// Arithmetic results
	logic signed [wpa_pkg::DATA_W-1:0] prev_q;
	logic signed [wpa_pkg::DATA_W-1:0] mean_q;
	logic signed [wpa_pkg::DATA_W-1:0] deriv_q;
	logic signed [wpa_pkg::PROD_W-1:0] prod_q;
	logic signed [wpa_pkg::WIDE_W-1:0] acc_q;

	// Result register
	logic signed [wpa_pkg::DATA_W-1:0] drive_q;
	logic signed [wpa_pkg::DATA_W-1:0] error_out_q;
	logic [wpa_pkg::COUNT_OUT_W-1:0]   wcount_q;

	logic signed [wpa_pkg::DIFF_W-1:0] raw_diff;
	logic signed [wpa_pkg::DIFF_W-1:0] e_sat;
	logic signed [wpa_pkg::DIFF_W-1:0] e_lo;
	logic signed [wpa_pkg::DIFF_W-1:0] e_wrap;
	logic [IDX_W:0]                    cnt_wide;
	logic [IDX_W-1:0]                  cnt;
	logic [IDX_W-1:0]                  tail_prev;
	logic [IDX_W-1:0]                  head_next;
	logic [IDX_W-1:0]                  tail_next;
	logic [IDX_W-1:0]                  ram_raddr;
	logic [wpa_pkg::DATA_W-1:0]        ram_rdata;
	logic signed [wpa_pkg::DIFF_W-1:0] step_diff;
	logic signed [wpa_pkg::DIV_W-1:0]  num_sel;
	logic [wpa_pkg::DIV_W-1:0]         num_mag;
	logic                              num_neg;
	logic [wpa_pkg::DATA_W-1:0]        den_sel;
	logic                              div_start;
	logic signed [wpa_pkg::WIDE_W-1:0] div_quo;
	logic                              div_done;
	logic signed [wpa_pkg::DATA_W-1:0] mul_a;
	logic signed [wpa_pkg::DATA_W-1:0] mul_b;
	logic signed [wpa_pkg::WIDE_W-1:0] term;

	// Error: saturate the difference, then wrap once in angular mode
	always_comb begin
		raw_diff = wpa_pkg::DIFF_W'(in_measured) - wpa_pkg::DIFF_W'(in_target);
		if (raw_diff > wpa_pkg::DIFF_W'(wpa_pkg::S32_MAX)) begin
			e_sat = wpa_pkg::DIFF_W'(wpa_pkg::S32_MAX);
		end else if (raw_diff < wpa_pkg::DIFF_W'(wpa_pkg::S32_MIN)) begin
			e_sat = wpa_pkg::DIFF_W'(wpa_pkg::S32_MIN);
		end else begin
			e_sat = raw_diff;
		end
		e_lo = e_sat;
		if (angular_q && (e_sat < -wpa_pkg::DIFF_W'(wpa_pkg::Q_PI))) begin
			e_lo = e_sat + wpa_pkg::DIFF_W'(wpa_pkg::Q_TWO_PI);
		end
		e_wrap = e_lo;
		if (angular_q && (e_lo > wpa_pkg::DIFF_W'(wpa_pkg::Q_PI))) begin
			e_wrap = e_lo - wpa_pkg::DIFF_W'(wpa_pkg::Q_TWO_PI);
		end
	end

	// Window occupancy and ring pointers
	always_comb begin
		if (tail_q >= head_q) begin
			cnt_wide = {1'b0, tail_q} - {1'b0, head_q};
		end else begin
			cnt_wide = {1'b0, tail_q} + DEPTH_W - {1'b0, head_q};
		end
		cnt       = cnt_wide[IDX_W-1:0];
		tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
		head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
		tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
		ram_raddr = (cmd.op == wpa_pkg::OP_RD_HEAD) ? head_q : tail_prev;
	end

	wpa_ram #(
		.WIDTH(wpa_pkg::DATA_W),
		.DEPTH(HISTORY_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (cmd.op == wpa_pkg::OP_PUSH),
		.waddr(tail_q),
		.wdata(e_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Divider operands: window sum over count, or scaled step over step time
	always_comb begin
		step_diff = wpa_pkg::DIFF_W'(e_q) - wpa_pkg::DIFF_W'(prev_q);
		if (cmd.op == wpa_pkg::OP_DIV_MEAN) begin
			num_sel = wpa_pkg::DIV_W'(sum_q);
			den_sel = wpa_pkg::DATA_W'(cnt);
		end else begin
			num_sel = wpa_pkg::DIV_W'(step_diff) <<< wpa_pkg::FRAC_W;
			den_sel = dt_q;
		end
		num_neg   = num_sel[wpa_pkg::DIV_W-1];
		num_mag   = num_neg ? -num_sel : num_sel;
		div_start = (cmd.op == wpa_pkg::OP_DIV_MEAN) || (cmd.op == wpa_pkg::OP_DIV_DERIV);
	end

	wpa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.neg   (num_neg),
		.mag   (num_mag),
		.den   (den_sel),
		.quo   (div_quo),
		.done  (div_done)
	);

	// Shared multiplier operands and the floored Q16 term from the last product
	always_comb begin
		case (cmd.op)
			wpa_pkg::OP_MUL_I: begin
				mul_a = gain_integ_q;
				mul_b = mean_q;
			end
			wpa_pkg::OP_MUL_D: begin
				mul_a = gain_deriv_q;
				mul_b = deriv_q;
			end
			default: begin
				mul_a = gain_prop_q;
				mul_b = e_q;
			end
		endcase
		term = wpa_pkg::WIDE_W'(prod_q >>> wpa_pkg::FRAC_W);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= '0;
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
			angular_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (wpa_pkg::cfg_reg_t'(cfg_idx))
				wpa_pkg::REG_GAIN_PROP:    gain_prop_q  <= cfg_data;
				wpa_pkg::REG_GAIN_INTEG:   gain_integ_q <= cfg_data;
				wpa_pkg::REG_GAIN_DERIV:   gain_deriv_q <= cfg_data;
				wpa_pkg::REG_ANGULAR_MODE: angular_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Ring pointers and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			sum_q  <= '0;
		end else begin
			case (cmd.op)
				wpa_pkg::OP_DROP: begin
					sum_q  <= sum_q - wpa_pkg::SUM_W'($signed(ram_rdata));
					head_q <= head_next;
				end
				wpa_pkg::OP_PUSH: begin
					sum_q  <= sum_q + wpa_pkg::SUM_W'(e_q);
					tail_q <= tail_next;
				end
				wpa_pkg::OP_OUT_CLEAR: begin
					sum_q  <= '0;
					head_q <= '0;
					tail_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Item capture, arithmetic and result registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			wpa_pkg::OP_CAPTURE: begin
				func_q  <= in_func;
				dt_q    <= in_step_time;
				e_q     <= wpa_pkg::DATA_W'(e_wrap);
				full_q  <= (cnt == LAST_IDX);
				empty_q <= (cnt == '0);
			end
			wpa_pkg::OP_TAKE_PREV: prev_q <= ram_rdata;
			wpa_pkg::OP_SELF_PREV: prev_q <= e_q;
			wpa_pkg::OP_DIV_DERIV: mean_q <= wpa_pkg::DATA_W'(div_quo);
			wpa_pkg::OP_MUL_P: begin
				deriv_q <= wpa_pkg::sat32(div_quo);
				prod_q  <= mul_a * mul_b;
				acc_q   <= '0;
			end
			wpa_pkg::OP_MUL_I, wpa_pkg::OP_MUL_D: begin
				prod_q <= mul_a * mul_b;
				acc_q  <= acc_q + term;
			end
			wpa_pkg::OP_ACC: acc_q <= acc_q + term;
			wpa_pkg::OP_OUT_RUN: begin
				drive_q     <= wpa_pkg::sat32(acc_q);
				error_out_q <= e_q;
				wcount_q    <= wpa_pkg::COUNT_OUT_W'(cnt);
			end
			wpa_pkg::OP_OUT_SKIP: begin
				drive_q     <= '0;
				error_out_q <= e_q;
				wcount_q    <= wpa_pkg::COUNT_OUT_W'(cnt);
			end
			wpa_pkg::OP_OUT_CLEAR: begin
				drive_q     <= '0;
				error_out_q <= '0;
				wcount_q    <= '0;
			end
			default: ;
		endcase
	end

	assign status.func     = func_q;
	assign status.dt_zero  = (dt_q == '0);
	assign status.full     = full_q;
	assign status.empty    = empty_q;
	assign status.div_done = div_done;

	assign drive        = drive_q;
	assign error_out    = error_out_q;
	assign window_count = wcount_q;

endmodule
`default_nettype wire

// File: rtl/core/wpa_ctrl.sv
`default_nettype none
`include "windowed_pid_angular_core_defines.svh"
module wpa_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire wpa_pkg::dp_status_t  status,
	output wpa_pkg::dp_cmd_t          cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_RD_HEAD,
		S_DROP,
		S_PREV,
		S_TAKE_PREV,
		S_PUSH,
		S_DIV_MEAN,
		S_WAIT_MEAN,
		S_DIV_DERIV,
		S_WAIT_DERIV,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_ACC,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode per state
	always_comb begin
		cmd.op = wpa_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE:       cmd.op = in_valid ? wpa_pkg::OP_CAPTURE : wpa_pkg::OP_NONE;
			S_RD_HEAD:    cmd.op = wpa_pkg::OP_RD_HEAD;
			S_DROP:       cmd.op = wpa_pkg::OP_DROP;
			S_PREV:       cmd.op = status.empty ? wpa_pkg::OP_SELF_PREV : wpa_pkg::OP_RD_PREV;
			S_TAKE_PREV:  cmd.op = wpa_pkg::OP_TAKE_PREV;
			S_PUSH:       cmd.op = wpa_pkg::OP_PUSH;
			S_DIV_MEAN:   cmd.op = wpa_pkg::OP_DIV_MEAN;
			S_DIV_DERIV:  cmd.op = wpa_pkg::OP_DIV_DERIV;
			S_MUL_P:      cmd.op = wpa_pkg::OP_MUL_P;
			S_MUL_I:      cmd.op = wpa_pkg::OP_MUL_I;
			S_MUL_D:      cmd.op = wpa_pkg::OP_MUL_D;
			S_ACC:        cmd.op = wpa_pkg::OP_ACC;
			S_FINISH: begin
				if (out_free) begin
					if (status.func) begin
						cmd.op = wpa_pkg::OP_OUT_CLEAR;
					end else if (status.dt_zero) begin
						cmd.op = wpa_pkg::OP_OUT_SKIP;
					end else begin
						cmd.op = wpa_pkg::OP_OUT_RUN;
					end
				end
			end
			default:      cmd.op = wpa_pkg::OP_NONE;
		endcase
	end

	// State sequence and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a finished item, drop it after a transfer
			if ((state_q == S_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (status.func || status.dt_zero) begin
						state_q <= S_FINISH;
					end else if (status.full) begin
						state_q <= S_RD_HEAD;
					end else begin
						state_q <= S_PREV;
					end
				end
				S_RD_HEAD:   state_q <= S_DROP;
				S_DROP:      state_q <= S_PREV;
				S_PREV:      state_q <= status.empty ? S_PUSH : S_TAKE_PREV;
				S_TAKE_PREV: state_q <= S_PUSH;
				S_PUSH:      state_q <= S_DIV_MEAN;
				S_DIV_MEAN:  state_q <= S_WAIT_MEAN;
				S_WAIT_MEAN: begin
					if (status.div_done) begin
						state_q <= S_DIV_DERIV;
					end
				end
				S_DIV_DERIV: state_q <= S_WAIT_DERIV;
				S_WAIT_DERIV: begin
					if (status.div_done) begin
						state_q <= S_MUL_P;
					end
				end
				S_MUL_P:     state_q <= S_MUL_I;
				S_MUL_I:     state_q <= S_MUL_D;
				S_MUL_D:     state_q <= S_ACC;
				S_ACC:       state_q <= S_FINISH;
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	`WPA_ASSERT(a_result_from_finish, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_FINISH))
	`WPA_ASSERT(a_accept_to_decide, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_DECIDE))
	`WPA_ASSERT_NEVER(a_div_done_unexpected, clk, arst_n, status.div_done && (state_q != S_WAIT_MEAN) && (state_q != S_WAIT_DERIV))

endmodule
`default_nettype wire
